/* rtl/core/stp_pkg.sv */
// stp_pkg: item types, command control, status structs and codes
// for the skeleton thinning pass; no dependencies
`default_nettype none
package stp_pkg;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_PAD   = 1'b1;

    localparam logic [1:0] REG_PRUNE  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [1:0]  PRUNE_RESET  = 2'd0;
    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [10:0] HEIGHT_RESET = 11'd1024;

    localparam logic [7:0] CODE_ERODE_A = 8'd54;
    localparam logic [7:0] CODE_ERODE_B = 8'd216;
    localparam logic [7:0] CODE_KEEP_A  = 8'd99;
    localparam logic [7:0] CODE_KEEP_B  = 8'd141;

    typedef struct packed {
        logic       req_type;
        logic [7:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic       last_of_frame;
    } out_item_t;

    typedef struct packed {
        logic push;
        logic emit;
        logic last;
        logic up;
        logic dn;
        logic lf;
        logic rt;
    } cmd_ctl_t;

    typedef struct packed {
        logic inject_busy;
    } front_stat_t;

    typedef struct packed {
        logic emit_pending;
    } back_stat_t;

endpackage
`default_nettype wire

/* rtl/core/stp_queue.sv */
// stp_queue: two-entry command queue between front and back
// no package dependencies
`default_nettype none
module stp_queue #(
    parameter int W = 8
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          wr_en,
    input  wire  [W-1:0] wr_data,
    output logic         wr_ready,
    input  wire          rd_en,
    output logic [W-1:0] rd_data,
    output logic         rd_valid
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_en && wr_ready) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_en && wr_ready) wp_reg <= ~wp_reg;
            if (rd_en && rd_valid) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_en && wr_ready) - 2'(rd_en && rd_valid);
        end
    end
endmodule
`default_nettype wire

/* rtl/core/stp_front.sv */
// stp_front: accepts items, tracks input and result positions, issues commands
// depends on stp_pkg
`default_nettype none
module stp_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  stp_pkg::in_item_t                 s_item,
    input  wire  [10:0]                       width_cfg,
    input  wire  [10:0]                       height_cfg,
    input  wire                               cfg_restart,
    output logic                              q_wr,
    input  wire                               q_ready,
    output stp_pkg::cmd_ctl_t                 q_ctl,
    output logic [PIXEL_BITS-1:0]             q_value,
    output logic [$clog2(MAX_WIDTH)-1:0]      q_pcol,
    output logic [$clog2(MAX_WIDTH)-1:0]      q_ecol,
    output stp_pkg::front_stat_t              stat
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WEW = CW + 1;
    localparam int HEW = RW + 1;
    localparam int XW  = (PIXEL_BITS > 8) ? PIXEL_BITS : 8;

    logic [WEW-1:0] weff;
    logic [HEW-1:0] heff;
    logic [CW-1:0]  in_col_reg, e_col_reg;
    logic [RW-1:0]  in_row_reg, e_row_reg;
    logic           done_reg;
    logic [1:0]     inj_reg;
    logic           acc, is_pix, inj_cmd, col_last, pix_last, primed, e_col_last;
    logic [XW-1:0]  pix_x;

    always_comb begin
        if (width_cfg == 11'd0) weff = WEW'(1);
        else if (32'(width_cfg) > MAX_WIDTH) weff = WEW'(MAX_WIDTH);
        else weff = WEW'(width_cfg);
        if (height_cfg == 11'd0) heff = HEW'(1);
        else if (32'(height_cfg) > MAX_HEIGHT) heff = HEW'(MAX_HEIGHT);
        else heff = HEW'(height_cfg);
    end

    assign s_ready  = (inj_reg == 2'd0) && q_ready;
    assign acc      = s_valid && s_ready;
    assign is_pix   = !done_reg && (s_item.req_type == stp_pkg::REQ_PIXEL);
    assign inj_cmd  = (inj_reg != 2'd0) && q_ready;
    assign col_last = WEW'(in_col_reg) == weff - WEW'(1);
    assign pix_last = col_last && (HEW'(in_row_reg) == heff - HEW'(1));
    assign primed   = (in_row_reg != '0 && in_col_reg != '0) || in_row_reg > RW'(1);
    assign e_col_last = WEW'(e_col_reg) == weff - WEW'(1);
    assign pix_x    = XW'(s_item.pixel_value);

    assign q_wr = inj_cmd || (acc && (is_pix || done_reg));
    assign stat.inject_busy = inj_reg != 2'd0;

    always_comb begin
        q_ctl.push = 1'b1;
        q_ctl.emit = inj_cmd ? 1'b0 : (is_pix ? primed : 1'b1);
        q_ctl.up   = e_row_reg != '0;
        q_ctl.dn   = HEW'(e_row_reg) != heff - HEW'(1);
        q_ctl.lf   = e_col_reg != '0;
        q_ctl.rt   = !e_col_last;
        q_ctl.last = !q_ctl.dn && !q_ctl.rt;
        q_value    = (is_pix && !inj_cmd) ? pix_x[PIXEL_BITS-1:0] : '0;
        q_pcol     = in_col_reg;
        q_ecol     = e_col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_restart) begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            e_col_reg  <= '0;
            e_row_reg  <= '0;
            done_reg   <= 1'b0;
            inj_reg    <= 2'd0;
        end else if (q_wr) begin
            in_col_reg <= col_last ? '0 : in_col_reg + CW'(1);
            if (inj_cmd) begin
                inj_reg <= inj_reg - 2'd1;
            end else if (is_pix) begin
                if (pix_last) begin
                    done_reg <= 1'b1;
                    if (heff == HEW'(1)) inj_reg <= 2'd1;
                end else if (col_last) begin
                    in_row_reg <= in_row_reg + RW'(1);
                end
            end
            if (q_ctl.emit) begin
                if (q_ctl.last) begin
                    in_col_reg <= '0;
                    in_row_reg <= '0;
                    e_col_reg  <= '0;
                    e_row_reg  <= '0;
                    done_reg   <= 1'b0;
                end else if (e_col_last) begin
                    e_col_reg <= '0;
                    e_row_reg <= e_row_reg + RW'(1);
                end else begin
                    e_col_reg <= e_col_reg + CW'(1);
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/stp_back.sv */
// stp_back: pixel window, line and decided-row memories, thinning decision
// depends on stp_pkg
`default_nettype none
module stp_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           q_valid,
    output logic                          q_rd,
    input  stp_pkg::cmd_ctl_t             q_ctl,
    input  wire  [PIXEL_BITS-1:0]         q_value,
    input  wire  [$clog2(MAX_WIDTH)-1:0]  q_pcol,
    input  wire  [$clog2(MAX_WIDTH)-1:0]  q_ecol,
    input  wire  [1:0]                    prune_level,
    output logic                          m_valid,
    input  wire                           m_ready,
    output stp_pkg::out_item_t            m_item,
    output stp_pkg::back_stat_t           stat
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PB = PIXEL_BITS;
    localparam int XW = (PB > 8) ? PB : 8;

    logic [PB-1:0] lmem [MAX_WIDTH];
    logic [PB-1:0] dmem [MAX_WIDTH];

    logic [PB-1:0] p0_reg, p1_reg, p2_reg, q0_reg, q1_reg;
    logic [PB-1:0] up_reg, ur_reg, left_reg, hold_reg, dec;
    logic          b_emit_reg, m_valid_reg;
    stp_pkg::cmd_ctl_t b_ctl_reg;
    logic [CW-1:0] b_col_reg, ur_addr;
    logic          a_go, b_go, er;
    logic [7:0]    z, g;
    logic [PB-1:0] n [8];
    logic [XW-1:0] dx;

    function automatic logic thin_erode(input logic [7:0] zz, input logic [7:0] gg,
                                        input logic [1:0] pl);
        logic [2:0] faces, corners;
        logic       e, dia, c135;
        e = 1'b0;
        faces   = 3'(zz[0]) + 3'(zz[2]) + 3'(zz[4]) + 3'(zz[6]);
        corners = 3'(zz[1]) + 3'(zz[3]) + 3'(zz[5]) + 3'(zz[7]);
        if (zz == stp_pkg::CODE_ERODE_A || zz == stp_pkg::CODE_ERODE_B) return 1'b1;
        if (zz == stp_pkg::CODE_KEEP_A || zz == stp_pkg::CODE_KEEP_B) return 1'b0;
        if (faces == 3'd2 && corners == 3'd0 && zz[2] && zz[4]) e = 1'b1;
        if (pl > 2'd1 && ({1'b0, faces} + {1'b0, corners}) <= 4'd1) e = 1'b1;
        if (!zz[0] || !zz[2] || !zz[4] || !zz[6]) begin
            dia = pl > 2'd1 || faces != 3'd1 || corners != 3'd2 ||
                  ((!zz[1] || !zz[2] || !zz[3]) && (!zz[3] || !zz[4] || !zz[5]) &&
                   (!zz[5] || !zz[6] || !zz[7]) && (!zz[7] || !zz[0] || !zz[1]));
            if (dia) begin
                c135 = pl != 2'd0 || faces != 3'd2 || corners != 3'd2;
                if (!c135) begin
                    c135 = 1'b1;
                    for (int a = 0; a < 8; a++) begin
                        if (zz[a] && zz[(a + 1) & 7] && zz[(a + 2) & 7] && !zz[(a + 3) & 7])
                            c135 = 1'b0;
                    end
                end
                if (c135 &&
                    (!zz[1] || gg[0] || gg[2]) && (!zz[3] || gg[2] || gg[4]) &&
                    (!zz[5] || gg[4] || gg[6]) && (!zz[7] || gg[6] || gg[0]) &&
                    (!zz[0] || !zz[4] || gg[2] || gg[6]) &&
                    (!zz[2] || !zz[6] || gg[0] || gg[4])) begin
                    if (pl > 2'd1 || faces > 3'd2 || (faces == 3'd2 && corners > 3'd1))
                        e = 1'b1;
                end
            end
        end
        return e;
    endfunction

    assign b_go  = b_emit_reg && (!m_valid_reg || m_ready);
    assign a_go  = q_valid && (!b_emit_reg || b_go);
    assign q_rd  = a_go;
    assign ur_addr = q_ecol + CW'(1);
    assign m_valid = m_valid_reg;
    assign stat.emit_pending = b_emit_reg;

    always_comb begin
        n[0] = b_ctl_reg.lf ? left_reg : '0;
        n[1] = (b_ctl_reg.up && b_ctl_reg.lf) ? hold_reg : '0;
        n[2] = b_ctl_reg.up ? up_reg : '0;
        n[3] = (b_ctl_reg.up && b_ctl_reg.rt) ? ur_reg : '0;
        n[4] = b_ctl_reg.rt ? q0_reg : '0;
        n[5] = (b_ctl_reg.dn && b_ctl_reg.rt) ? p0_reg : '0;
        n[6] = b_ctl_reg.dn ? p1_reg : '0;
        n[7] = (b_ctl_reg.dn && b_ctl_reg.lf) ? p2_reg : '0;
        for (int a = 0; a < 8; a++) begin
            z[a] = n[a] != '0;
            g[a] = n[a] > PB'(1);
        end
        er = thin_erode(z, g, prune_level);
        if (q1_reg == '0) dec = '0;
        else if (er) dec = PB'(1);
        else dec = q1_reg;
        dx = XW'(dec);
    end

    always_ff @(posedge aclk) begin
        if (a_go && q_ctl.push) begin
            lmem[q_pcol] <= q_value;
            q0_reg <= lmem[q_pcol];
            q1_reg <= q0_reg;
            p0_reg <= q_value;
            p1_reg <= p0_reg;
            p2_reg <= p1_reg;
        end
        if (a_go && q_ctl.emit) begin
            up_reg <= (b_go && b_col_reg == q_ecol) ? dec : dmem[q_ecol];
            ur_reg <= (b_go && b_col_reg == ur_addr) ? dec : dmem[ur_addr];
            b_ctl_reg <= q_ctl;
            b_col_reg <= q_ecol;
        end
        if (b_go) begin
            dmem[b_col_reg] <= dec;
            left_reg <= dec;
            hold_reg <= up_reg;
            m_item.out_pixel <= (dec <= PB'(1)) ? 8'd0 : dx[7:0];
            m_item.last_of_frame <= b_ctl_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_emit_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_go) b_emit_reg <= q_ctl.emit;
            else if (b_go) b_emit_reg <= 1'b0;
            if (b_go) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/skeleton_thinning_pass_3x3.sv */
// skeleton_thinning_pass_3x3: top level with register port, front, queue and back
// depends on stp_pkg, stp_front, stp_queue, stp_back
//
// One thinning pass over a raster-order pixel plane, one item per clock
// sustained while results drain and no window step is inserted. Each result
// leaves one row plus one pixel after its input pixel; after the last pixel
// of a frame, pad items (or further pixels) flush the remaining results, one
// per item. For single-row frames the front inserts one internal window step
// after the last pixel, holding s_ready low until that step is queued. From
// acceptance of the causing item to m_valid: the queue entry, then window and
// memory read, with the decision registered at the output. Writing width or
// height restarts the frame; prune level applies to the next decision.
`default_nettype none
module skeleton_thinning_pass_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  stp_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  wire                 m_ready,
    output stp_pkg::out_item_t  m_item,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [3:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = $bits(stp_pkg::cmd_ctl_t) + PIXEL_BITS + 2 * CW;

    logic [1:0]  prune_reg;
    logic [10:0] width_reg, height_reg;
    logic        wr, restart;
    logic [1:0]  idx;

    stp_pkg::cmd_ctl_t    f_ctl, b_ctl;
    logic [PIXEL_BITS-1:0] f_val, b_val;
    logic [CW-1:0]        f_pcol, f_ecol, b_pcol, b_ecol;
    logic                 q_wr, q_ready, q_rd, q_valid;
    logic [QW-1:0]        q_out;
    stp_pkg::front_stat_t fstat;
    stp_pkg::back_stat_t  bstat;

    assign pready  = 1'b1;
    assign idx     = paddr[3:2];
    assign wr      = psel && penable && pwrite;
    assign restart = wr && (idx == stp_pkg::REG_WIDTH || idx == stp_pkg::REG_HEIGHT);

    always_comb begin
        unique case (idx)
            stp_pkg::REG_PRUNE:  prdata = 32'(prune_reg);
            stp_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            stp_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prune_reg  <= stp_pkg::PRUNE_RESET;
            width_reg  <= stp_pkg::WIDTH_RESET;
            height_reg <= stp_pkg::HEIGHT_RESET;
        end else if (wr) begin
            if (idx == stp_pkg::REG_PRUNE)  prune_reg  <= pwdata[1:0];
            if (idx == stp_pkg::REG_WIDTH)  width_reg  <= pwdata[10:0];
            if (idx == stp_pkg::REG_HEIGHT) height_reg <= pwdata[10:0];
        end
    end

    stp_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .PIXEL_BITS(PIXEL_BITS)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .width_cfg(width_reg), .height_cfg(height_reg), .cfg_restart(restart),
        .q_wr(q_wr), .q_ready(q_ready), .q_ctl(f_ctl), .q_value(f_val),
        .q_pcol(f_pcol), .q_ecol(f_ecol), .stat(fstat)
    );

    stp_queue #(.W(QW)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(q_wr), .wr_data({f_ctl, f_val, f_pcol, f_ecol}), .wr_ready(q_ready),
        .rd_en(q_rd), .rd_data(q_out), .rd_valid(q_valid)
    );

    assign {b_ctl, b_val, b_pcol, b_ecol} = q_out;

    stp_back #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_rd(q_rd), .q_ctl(b_ctl), .q_value(b_val),
        .q_pcol(b_pcol), .q_ecol(b_ecol), .prune_level(prune_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item), .stat(bstat)
    );

    a_inject_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        fstat.inject_busy |-> !s_ready)
        else $error("input taken during window injection");

    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (bstat.emit_pending && m_valid && !m_ready) |=> bstat.emit_pending)
        else $error("pending decision lost under output stall");

    a_stall_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (bstat.emit_pending && m_valid && !m_ready) |-> !q_rd)
        else $error("command popped while decision stage stalled");
endmodule
`default_nettype wire

/* dv/testbench.sv */
// testbench: self-checking bench for skeleton_thinning_pass_3x3
// depends on stp_pkg and the block's rtl; holds its own thinning predictor
`timescale 1ns / 100ps
module testbench;

    localparam int MAXW = 1024;
    localparam int MAXH = 1024;
    localparam int IDLE_LIMIT = 3000;

    class thin_scoreboard;
        int unsigned prune, width_reg, height_reg;
        logic [7:0] decided_row[MAXW];
        logic [7:0] orig_px[MAXW + 1];
        int unsigned col, row, emitted, upleft;
        bit input_done;
        stp_pkg::out_item_t expected_q[$];

        function new();
            prune = stp_pkg::PRUNE_RESET;
            width_reg = stp_pkg::WIDTH_RESET;
            height_reg = stp_pkg::HEIGHT_RESET;
            restart();
        endfunction

        function void restart();
            col = 0;
            row = 0;
            emitted = 0;
            input_done = 0;
            upleft = 0;
        endfunction

        function int unsigned eff_w();
            return width_reg < 1 ? 1 : (width_reg > MAXW ? MAXW : width_reg);
        endfunction

        function int unsigned eff_h();
            return height_reg < 1 ? 1 : (height_reg > MAXH ? MAXH : height_reg);
        endfunction

        function void configure(logic [1:0] idx, logic [31:0] val);
            if (idx == stp_pkg::REG_PRUNE) begin
                prune = val & 3;
            end else if (idx == stp_pkg::REG_WIDTH) begin
                width_reg = val & 'h7ff;
                restart();
            end else if (idx == stp_pkg::REG_HEIGHT) begin
                height_reg = val & 'h7ff;
                restart();
            end
        endfunction

        function int unsigned thin_value(int unsigned center, int unsigned nb[8]);
            bit z[8], g[8];
            bit er, diamond_ok, c135;
            int unsigned code, faces, corners;
            er = 0;
            code = 0;
            if (center == 0) return 0;
            for (int a = 0; a < 8; a++) begin
                z[a] = nb[a] != 0;
                g[a] = nb[a] > 1;
                if (z[a]) code |= 1 << a;
            end
            if (code == stp_pkg::CODE_ERODE_A || code == stp_pkg::CODE_ERODE_B) return 1;
            if (code == stp_pkg::CODE_KEEP_A || code == stp_pkg::CODE_KEEP_B) return center;
            faces = z[0] + z[2] + z[4] + z[6];
            corners = z[1] + z[3] + z[5] + z[7];
            if (faces == 2 && corners == 0 && z[2] && z[4]) er = 1;
            if (prune > 1 && faces + corners <= 1) er = 1;
            if (!z[0] || !z[2] || !z[4] || !z[6]) begin
                diamond_ok = prune > 1 || faces != 1 || corners != 2 ||
                    ((!z[1] || !z[2] || !z[3]) && (!z[3] || !z[4] || !z[5]) &&
                     (!z[5] || !z[6] || !z[7]) && (!z[7] || !z[0] || !z[1]));
                if (diamond_ok) begin
                    c135 = prune != 0 || faces != 2 || corners != 2;
                    if (!c135) begin
                        c135 = 1;
                        for (int a = 0; a < 8; a++)
                            if (z[a] && z[(a + 1) % 8] && z[(a + 2) % 8] && !z[(a + 3) % 8])
                                c135 = 0;
                    end
                    if (c135 &&
                        (!z[1] || g[0] || g[2]) && (!z[3] || g[2] || g[4]) &&
                        (!z[5] || g[4] || g[6]) && (!z[7] || g[6] || g[0]) &&
                        (!z[0] || !z[4] || g[2] || g[6]) &&
                        (!z[2] || !z[6] || g[0] || g[4])) begin
                        if (prune > 1 || faces > 2 || (faces == 2 && corners > 1)) er = 1;
                    end
                end
            end
            return er ? 1 : center;
        endfunction

        function int unsigned orig_at(int unsigned idx, bit have_new,
                                      int unsigned new_idx, int unsigned new_val);
            if (have_new && idx == new_idx) return new_val;
            return orig_px[idx % (MAXW + 1)];
        endfunction

        function void emit_next(bit have_new, int unsigned new_idx, int unsigned new_val);
            int unsigned w, h, e, r, c, center, dec;
            int unsigned nb[8];
            bit up, dn, lf, rt;
            stp_pkg::out_item_t res;
            w = eff_w();
            h = eff_h();
            e = emitted;
            r = e / w;
            c = e % w;
            up = r > 0;
            dn = r + 1 < h;
            lf = c > 0;
            rt = c + 1 < w;
            center = orig_at(e, have_new, new_idx, new_val);
            nb[0] = lf ? decided_row[c - 1] : 0;
            nb[1] = (up && lf) ? upleft : 0;
            nb[2] = up ? decided_row[c] : 0;
            nb[3] = (up && rt) ? decided_row[c + 1] : 0;
            nb[4] = rt ? orig_at(e + 1, have_new, new_idx, new_val) : 0;
            nb[5] = (dn && rt) ? orig_at(e + w + 1, have_new, new_idx, new_val) : 0;
            nb[6] = dn ? orig_at(e + w, have_new, new_idx, new_val) : 0;
            nb[7] = (dn && lf) ? orig_at(e + w - 1, have_new, new_idx, new_val) : 0;
            dec = thin_value(center, nb);
            upleft = decided_row[c];
            decided_row[c] = dec;
            res.out_pixel = dec <= 1 ? 8'd0 : dec[7:0];
            res.last_of_frame = e == w * h - 1;
            expected_q.push_back(res);
            if (e == w * h - 1) restart();
            else emitted = e + 1;
        endfunction

        function void note_item(stp_pkg::in_item_t it);
            int unsigned w, h, k;
            w = eff_w();
            h = eff_h();
            if (!input_done && it.req_type == stp_pkg::REQ_PIXEL) begin
                k = row * w + col;
                if (k == emitted + w + 1) emit_next(1, k, it.pixel_value);
                orig_px[k % (MAXW + 1)] = it.pixel_value;
                col++;
                if (col >= w) begin
                    col = 0;
                    row++;
                end
                if (k + 1 >= w * h) input_done = 1;
            end else if (input_done) begin
                emit_next(0, 0, 0);
            end
        endfunction

        function bit check_result(stp_pkg::out_item_t got, output string why);
            stp_pkg::out_item_t want;
            if (expected_q.size() == 0) begin
                $sformat(why, "result %0d with nothing expected", got.out_pixel);
                return 0;
            end
            want = expected_q.pop_front();
            if (got.out_pixel !== want.out_pixel) begin
                $sformat(why, "out_pixel %0d, expected %0d", got.out_pixel, want.out_pixel);
                return 0;
            end
            if (got.last_of_frame !== want.last_of_frame) begin
                $sformat(why, "last_of_frame %0b, expected %0b",
                         got.last_of_frame, want.last_of_frame);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    stp_pkg::in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 0;
    stp_pkg::out_item_t m_item;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    thin_scoreboard sb = new();
    int errors = 0;
    int idle_cycles = 0;
    int items_in = 0;
    int results_out = 0;
    int frames = 0;
    bit hold_off = 0;
    bit calm = 0;

    skeleton_thinning_pass_3x3 dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    task automatic report(string why);
        $display("mismatch at %0t: %s", $realtime, why);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        string why;
        if (aresetn && s_valid && s_ready) begin
            sb.note_item(s_item);
            items_in++;
        end
        if (aresetn && m_valid && m_ready) begin
            results_out++;
            if (!sb.check_result(m_item, why)) report(why);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge aclk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        int g;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 0;
                repeat (400) @(negedge aclk);
                hold_off = 0;
            end else begin
                g = pick_gap();
                if (g == 0) begin
                    m_ready <= 1;
                end else begin
                    m_ready <= 0;
                    repeat (g - 1) @(negedge aclk);
                end
            end
        end
    end

    task automatic send_item(logic kind, logic [7:0] value);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(negedge aclk);
        end
        s_valid <= 1;
        s_item.req_type <= kind;
        s_item.pixel_value <= value;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task automatic stop_sending();
        s_valid <= 0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        sb.configure(idx, val);
        @(negedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    function automatic logic [7:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 8'd0;
        if (r < 45) return 8'd1;
        if (r < 50) return 8'd255;
        return 8'($urandom_range(2, 255));
    endfunction

    // one frame; partial stops halfway so the next size write restarts it
    task automatic run_frame(int unsigned prune, int unsigned w, int unsigned h,
                             bit partial);
        int unsigned n;
        wait_drained();
        write_reg(stp_pkg::REG_PRUNE, prune);
        write_reg(stp_pkg::REG_WIDTH, w);
        write_reg(stp_pkg::REG_HEIGHT, h);
        n = sb.eff_w() * sb.eff_h();
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0) send_item(stp_pkg::REQ_PAD, 8'($urandom));
            send_item(stp_pkg::REQ_PIXEL, pick_pixel());
            if (partial && k == n / 2) break;
        end
        while (sb.input_done) begin
            if ($urandom_range(0, 3) == 0) send_item(stp_pkg::REQ_PIXEL, 8'($urandom));
            else send_item(stp_pkg::REQ_PAD, 8'($urandom));
        end
        frames++;
    endtask

    initial begin
        int unsigned random_px;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: small planes, every prune level, pixel extremes, partial frame
        run_frame(0, 4, 3, 0);
        run_frame(1, 3, 3, 0);
        run_frame(2, 5, 2, 1);
        run_frame(3, 1, 1, 0);
        run_frame(0, 0, 3, 0);
        run_frame(2, 6, 1, 0);

        // long receiver hold-off while the sender keeps going
        wait_drained();
        hold_off = 1;
        run_frame(2, 12, 8, 0);

        random_px = 0;
        while (random_px < 360) begin
            int unsigned w, h;
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            calm = $urandom_range(0, 4) == 0;
            random_px += w * h;
            run_frame($urandom_range(0, 3), w, h, $urandom_range(0, 9) == 0);
        end
        calm = 0;

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("covered %0d frames across all prune levels and saturated sizes",
                 frames);
        $display("%0d items accepted, %0d results checked, %0d mismatches",
                 items_in, results_out, errors);
        if (errors == 0 && sb.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
